### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge out of reset.
`define FCPT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("assertion failed");

// An antecedent that must be followed by a consequent in the next cycle.
`define FCPT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/fcpt_pkg.sv
// ----------------------------------------------------------------------------
// FOC transform package
// Data widths, fixed-point constants, the quarter-wave sine table and the
// saturation helper shared by the transform pipeline.
// ----------------------------------------------------------------------------
package fcpt_pkg;

    localparam int DATA_W      = 16;
    localparam int FRAC_W      = DATA_W - 1;
    localparam int ANGLE_W     = 16;
    localparam int POS_W       = ANGLE_W - 2;
    localparam int SINE_DEPTH  = 256;
    localparam int SINE_ADDR_W = $clog2(SINE_DEPTH);
    localparam int SINE_IDX_W  = SINE_ADDR_W + 1;
    localparam int SAT_IN_W    = 24;

    localparam longint FULL_SCALE = (longint'(1) << FRAC_W) - 1;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic signed [31:0] ONE_BY_SQRT3_Q31 = 32'sd1239850262;
    localparam logic signed [31:0] SQRT3_BY_2_Q31   = 32'sd1859775393;

    localparam logic [63:0] TAYLOR_DIV [1:6] = '{64'd6, 64'd20, 64'd42,
                                                 64'd72, 64'd110, 64'd156};

    localparam logic signed [SAT_IN_W-1:0] SAT_MAX = SAT_IN_W'(FULL_SCALE);
    localparam logic signed [SAT_IN_W-1:0] SAT_MIN = SAT_IN_W'(-FULL_SCALE - 1);

    typedef logic [FRAC_W-1:0] t_sine_tab [0:SINE_DEPTH];

    function automatic t_sine_tab build_sine_tab();
        t_sine_tab         tab;
        logic [63:0]       x;
        logic [63:0]       term;
        logic signed [63:0] acc;
        logic [63:0]       e;
        for (int k = 0; k <= SINE_DEPTH; k++) begin
            x    = (HALF_PI_Q30 * 64'(k)) / SINE_DEPTH;
            term = x;
            acc  = signed'(x);
            for (int n = 1; n <= 6; n++) begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / TAYLOR_DIV[n];
                if (n % 2 == 1) begin
                    acc = acc - signed'(term);
                end else begin
                    acc = acc + signed'(term);
                end
            end
            if (acc < 0) begin
                acc = '0;
            end
            e = (64'(acc) * 64'(FULL_SCALE) + (64'd1 << 29)) >> 30;
            if (e > 64'(FULL_SCALE)) begin
                e = 64'(FULL_SCALE);
            end
            tab[k] = e[FRAC_W-1:0];
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = build_sine_tab();

    function automatic logic signed [DATA_W-1:0] sat(input logic signed [SAT_IN_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > SAT_MAX) begin
            r = DATA_W'(SAT_MAX);
        end else if (v < SAT_MIN) begin
            r = DATA_W'(SAT_MIN);
        end else begin
            r = DATA_W'(v);
        end
        return r;
    endfunction

endpackage

### rtl/fcpt_sincos.sv
// ----------------------------------------------------------------------------
// FOC sine and cosine lookup
// Registered quarter-wave table lookup of the sine and cosine of an angle.
// ----------------------------------------------------------------------------
module fcpt_sincos (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic [fcpt_pkg::ANGLE_W-1:0]       i_angle,
    output logic signed [fcpt_pkg::DATA_W-1:0] o_sin,
    output logic signed [fcpt_pkg::DATA_W-1:0] o_cos
);

    logic [1:0]                          w_quad;
    logic [fcpt_pkg::SINE_IDX_W-1:0]     w_idx;
    logic [fcpt_pkg::SINE_IDX_W-1:0]     w_idx_rev;
    logic [fcpt_pkg::FRAC_W-1:0]         w_sin_mag;
    logic [fcpt_pkg::FRAC_W-1:0]         w_cos_mag;
    logic signed [fcpt_pkg::DATA_W-1:0]  n_sin;
    logic signed [fcpt_pkg::DATA_W-1:0]  n_cos;
    logic signed [fcpt_pkg::DATA_W-1:0]  r_sin;
    logic signed [fcpt_pkg::DATA_W-1:0]  r_cos;

    always_comb begin
        w_quad    = i_angle[fcpt_pkg::ANGLE_W-1 -: 2];
        w_idx     = {1'b0, i_angle[fcpt_pkg::POS_W-1 -: fcpt_pkg::SINE_ADDR_W]};
        w_idx_rev = fcpt_pkg::SINE_IDX_W'(fcpt_pkg::SINE_DEPTH) - w_idx;
        w_sin_mag = w_quad[0] ? fcpt_pkg::SINE_TAB[w_idx_rev] : fcpt_pkg::SINE_TAB[w_idx];
        w_cos_mag = w_quad[0] ? fcpt_pkg::SINE_TAB[w_idx] : fcpt_pkg::SINE_TAB[w_idx_rev];
        n_sin     = signed'({1'b0, w_sin_mag});
        n_cos     = signed'({1'b0, w_cos_mag});
        if (w_quad[1]) begin
            n_sin = -n_sin;
        end
        if (w_quad[1] ^ w_quad[0]) begin
            n_cos = -n_cos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin <= n_sin;
            r_cos <= n_cos;
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

### rtl/foc_clarke_park_transform_unit.sv
// ----------------------------------------------------------------------------
// FOC Clarke/Park transform unit
// Throughput: one item per cycle while the output accepts, through a
// five-stage pipeline; each stage holds multiplies, round-and-saturate
// steps or both, and stalls on its own.
// Reset: i_rst_n, synchronous and active low, empties every stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module foc_clarke_park_transform_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // angle, current_a, current_b, current_c, volt_d_cmd, volt_q_cmd
    input  logic [95:0]  i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // current_d, current_q, volt_alpha, volt_beta, volt_a, volt_b, volt_c
    output logic [111:0] o_m_axis_tdata
);

    localparam int STAGES = 5;
    localparam int DW     = fcpt_pkg::DATA_W;
    localparam int FW     = fcpt_pkg::FRAC_W;

    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] w_en;

    logic [fcpt_pkg::ANGLE_W-1:0] w_angle;
    logic signed [DW-1:0] w_ia, w_ib, w_ic, w_vd, w_vq;
    logic signed [DW:0]   w_bdiff;
    logic signed [DW-1:0] w_sin, w_cos;

    logic signed [DW-1:0] r0_alpha, r0_vd, r0_vq;
    logic signed [48:0]   r0_bprod;

    logic signed [DW-1:0]   r1_beta, r1_sin, r1_cos;
    logic signed [2*DW-1:0] r1_vdc, r1_vqs, r1_vds, r1_vqc, r1_ac, r1_as;

    logic signed [DW-1:0]   r2_va, r2_vb;
    logic signed [2*DW-1:0] r2_bc, r2_bs, r2_ac, r2_as;

    logic signed [DW-1:0] r3_id, r3_iq, r3_va, r3_vb;
    logic signed [47:0]   r3_pprod;

    logic signed [DW-1:0] r4_id, r4_iq, r4_va, r4_vb, r4_pb, r4_pc;

    logic signed [48:0]     w_beta_rnd;
    logic signed [2*DW:0]   w_va_sum, w_vb_sum, w_id_sum, w_iq_sum;
    logic signed [49:0]     w_va_sh, w_pb_sum, w_pc_sum;

    always_comb begin
        w_en[STAGES-1] = !r_vld[STAGES-1] || i_m_axis_tready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_s_axis_tready = w_en[0];
    assign o_m_axis_tvalid = r_vld[STAGES-1];

    assign w_angle = i_s_axis_tdata[15:0];
    assign w_ia    = signed'(i_s_axis_tdata[31:16]);
    assign w_ib    = signed'(i_s_axis_tdata[47:32]);
    assign w_ic    = signed'(i_s_axis_tdata[63:48]);
    assign w_vd    = signed'(i_s_axis_tdata[79:64]);
    assign w_vq    = signed'(i_s_axis_tdata[95:80]);
    assign w_bdiff = (DW+1)'(w_ib) - (DW+1)'(w_ic);

    fcpt_sincos u_sincos (
        .i_clk   (i_clk),
        .i_en    (w_en[0]),
        .i_angle (w_angle),
        .o_sin   (w_sin),
        .o_cos   (w_cos)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_comb begin
        w_beta_rnd = (r0_bprod + 49'sd1073741824) >>> 31;
        w_va_sum   = (((2*DW+1)'(r1_vdc) - (2*DW+1)'(r1_vqs)) + (2*DW+1)'(1 << (FW - 1)))
                     >>> FW;
        w_vb_sum   = (((2*DW+1)'(r1_vds) + (2*DW+1)'(r1_vqc)) + (2*DW+1)'(1 << (FW - 1)))
                     >>> FW;
        w_id_sum   = (((2*DW+1)'(r2_ac) + (2*DW+1)'(r2_bs)) + (2*DW+1)'(1 << (FW - 1)))
                     >>> FW;
        w_iq_sum   = (((2*DW+1)'(r2_bc) - (2*DW+1)'(r2_as)) + (2*DW+1)'(1 << (FW - 1)))
                     >>> FW;
        w_va_sh    = 50'(r3_va) <<< 30;
        w_pb_sum   = ((50'(r3_pprod) - w_va_sh) + 50'sd1073741824) >>> 31;
        w_pc_sum   = ((-w_va_sh - 50'(r3_pprod)) + 50'sd1073741824) >>> 31;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r0_alpha <= w_ia;
            r0_vd    <= w_vd;
            r0_vq    <= w_vq;
            r0_bprod <= 49'(w_bdiff) * 49'(fcpt_pkg::ONE_BY_SQRT3_Q31);
        end
        if (w_en[1]) begin
            r1_beta <= fcpt_pkg::sat(fcpt_pkg::SAT_IN_W'(w_beta_rnd));
            r1_sin  <= w_sin;
            r1_cos  <= w_cos;
            r1_vdc  <= (2*DW)'(r0_vd) * (2*DW)'(w_cos);
            r1_vqs  <= (2*DW)'(r0_vq) * (2*DW)'(w_sin);
            r1_vds  <= (2*DW)'(r0_vd) * (2*DW)'(w_sin);
            r1_vqc  <= (2*DW)'(r0_vq) * (2*DW)'(w_cos);
            r1_ac   <= (2*DW)'(r0_alpha) * (2*DW)'(w_cos);
            r1_as   <= (2*DW)'(r0_alpha) * (2*DW)'(w_sin);
        end
        if (w_en[2]) begin
            r2_va <= fcpt_pkg::sat(fcpt_pkg::SAT_IN_W'(w_va_sum));
            r2_vb <= fcpt_pkg::sat(fcpt_pkg::SAT_IN_W'(w_vb_sum));
            r2_bc <= (2*DW)'(r1_beta) * (2*DW)'(r1_cos);
            r2_bs <= (2*DW)'(r1_beta) * (2*DW)'(r1_sin);
            r2_ac <= r1_ac;
            r2_as <= r1_as;
        end
        if (w_en[3]) begin
            r3_id    <= fcpt_pkg::sat(fcpt_pkg::SAT_IN_W'(w_id_sum));
            r3_iq    <= fcpt_pkg::sat(fcpt_pkg::SAT_IN_W'(w_iq_sum));
            r3_va    <= r2_va;
            r3_vb    <= r2_vb;
            r3_pprod <= 48'(r2_vb) * 48'(fcpt_pkg::SQRT3_BY_2_Q31);
        end
        if (w_en[4]) begin
            r4_id <= r3_id;
            r4_iq <= r3_iq;
            r4_va <= r3_va;
            r4_vb <= r3_vb;
            r4_pb <= fcpt_pkg::sat(fcpt_pkg::SAT_IN_W'(w_pb_sum));
            r4_pc <= fcpt_pkg::sat(fcpt_pkg::SAT_IN_W'(w_pc_sum));
        end
    end

    assign o_m_axis_tdata = {r4_pc, r4_pb, r4_va, r4_vb, r4_va, r4_iq, r4_id};

    `FCPT_ASSERT_NEXT(a_accept_fills_first, i_s_axis_tvalid && o_s_axis_tready, r_vld[0])
    `FCPT_ASSERT(a_ready_when_out_empty, !r_vld[STAGES-1] |-> o_s_axis_tready)
    `FCPT_ASSERT(a_phase_a_is_alpha,
        o_m_axis_tvalid |-> (o_m_axis_tdata[79:64] == o_m_axis_tdata[47:32]))

endmodule

### tb/foc_clarke_park_transform_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// FOC Clarke/Park transform unit testbench
// Streams angle, phase currents and d/q voltage commands into the transform unit
// and checks every result, field by field, against a given result or a predictor
// that rebuilds the quarter-wave sine table and repeats the fixed-point Clarke,
// Park, inverse Park and inverse Clarke arithmetic. A short table of directed
// items comes first, then random items with random idling on both sides.
// ----------------------------------------------------------------------------
module foc_clarke_park_transform_unit_tb;

    localparam int DW          = fcpt_pkg::DATA_W;
    localparam int QUARTER_LEN = 256;
    localparam int RANDOM_ITEMS = 650;
    localparam int CALM_ITEMS  = 80;
    localparam int HOLD_CYCLES = 300;

    localparam longint TOP_CODE     = (longint'(1) <<< (DW - 1)) - 1;
    localparam longint BOTTOM_CODE  = -(longint'(1) <<< (DW - 1));
    localparam longint INV_SQRT3_Q31 = 64'd1239850262;
    localparam longint HALF_SQRT3_Q31 = 64'd1859775393;
    localparam logic [63:0] QUARTER_PI2_Q30 = 64'd1686629713;

    typedef struct packed {
        logic signed [DW-1:0] volt_q_cmd;
        logic signed [DW-1:0] volt_d_cmd;
        logic signed [DW-1:0] current_c;
        logic signed [DW-1:0] current_b;
        logic signed [DW-1:0] current_a;
        logic [DW-1:0]        angle;
    } foc_in_t;

    typedef struct packed {
        logic signed [DW-1:0] volt_c;
        logic signed [DW-1:0] volt_b;
        logic signed [DW-1:0] volt_a;
        logic signed [DW-1:0] volt_beta;
        logic signed [DW-1:0] volt_alpha;
        logic signed [DW-1:0] current_q;
        logic signed [DW-1:0] current_d;
    } foc_out_t;

    typedef struct {
        foc_in_t  item;
        bit       typed;
        foc_out_t res;
    } stim_row_t;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    // angle, current_a, current_b, current_c, volt_d_cmd, volt_q_cmd
    logic [95:0]  i_s_axis_tdata;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    // current_d, current_q, volt_alpha, volt_beta, volt_a, volt_b, volt_c
    logic [111:0] o_m_axis_tdata;

    longint    quarter_wave [0:QUARTER_LEN];
    foc_out_t  expected_results [$];
    stim_row_t directed_rows [$];
    bit        offer_typed;
    foc_out_t  offer_res;
    foc_out_t  oldest_res;
    foc_out_t  seen_res;
    bit        hold_req;
    bit        calm;
    int        errors;

    foc_clarke_park_transform_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #4 i_clk = ~i_clk;

    // The sine of the first quarter turn, from a truncated Taylor series in Q30.
    initial begin
        logic [63:0] x;
        logic [63:0] term;
        longint      acc;
        longint      scaled;
        for (int k = 0; k <= QUARTER_LEN; k++) begin
            x    = (QUARTER_PI2_Q30 * 64'(k)) / 64'(QUARTER_LEN);
            term = x;
            acc  = longint'(x);
            for (int n = 1; n <= 6; n++) begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) begin
                    acc = acc - longint'(term);
                end else begin
                    acc = acc + longint'(term);
                end
            end
            if (acc < 0) begin
                acc = 0;
            end
            scaled = (acc * TOP_CODE + (longint'(1) <<< 29)) >>> 30;
            quarter_wave[k] = (scaled > TOP_CODE) ? TOP_CODE : scaled;
        end
    end

    function automatic longint sine_of(input logic [15:0] ang);
        logic [1:0] quad;
        longint     idx;
        longint     mag;
        quad = ang[15:14];
        idx  = (longint'(ang[13:0]) * QUARTER_LEN) >>> 14;
        mag  = quad[0] ? quarter_wave[QUARTER_LEN - idx] : quarter_wave[idx];
        return quad[1] ? -mag : mag;
    endfunction

    function automatic longint clamp(input longint v);
        if (v > TOP_CODE) begin
            return TOP_CODE;
        end
        if (v < BOTTOM_CODE) begin
            return BOTTOM_CODE;
        end
        return v;
    endfunction

    function automatic longint round_clamp(input longint v, input int s);
        return clamp((v + (longint'(1) <<< (s - 1))) >>> s);
    endfunction

    function automatic foc_out_t transform(input foc_in_t it);
        foc_out_t r;
        longint   sn;
        longint   cs;
        longint   i_al;
        longint   i_be;
        longint   v_al;
        longint   v_be;
        sn   = sine_of(it.angle);
        cs   = sine_of(it.angle + 16'h4000);
        i_al = clamp(longint'(it.current_a));
        i_be = round_clamp((longint'(it.current_b) - longint'(it.current_c)) * INV_SQRT3_Q31,
                           31);
        v_al = round_clamp(longint'(it.volt_d_cmd) * cs - longint'(it.volt_q_cmd) * sn,
                           DW - 1);
        v_be = round_clamp(longint'(it.volt_d_cmd) * sn + longint'(it.volt_q_cmd) * cs,
                           DW - 1);
        r.current_d  = DW'(round_clamp(i_al * cs + i_be * sn, DW - 1));
        r.current_q  = DW'(round_clamp(i_be * cs - i_al * sn, DW - 1));
        r.volt_alpha = DW'(v_al);
        r.volt_beta  = DW'(v_be);
        r.volt_a     = DW'(v_al);
        r.volt_b     = DW'(round_clamp(-v_al * (longint'(1) <<< 30) + HALF_SQRT3_Q31 * v_be,
                                       31));
        r.volt_c     = DW'(round_clamp(-v_al * (longint'(1) <<< 30) - HALF_SQRT3_Q31 * v_be,
                                       31));
        return r;
    endfunction

    function automatic foc_in_t make_item(input int ang, input int ia, input int ib,
                                          input int ic, input int vd, input int vq);
        foc_in_t it;
        it.angle      = DW'(ang);
        it.current_a  = DW'(ia);
        it.current_b  = DW'(ib);
        it.current_c  = DW'(ic);
        it.volt_d_cmd = DW'(vd);
        it.volt_q_cmd = DW'(vq);
        return it;
    endfunction

    function automatic foc_out_t make_res(input int cd, input int cq, input int val,
                                          input int vbe, input int va, input int vb,
                                          input int vc);
        foc_out_t r;
        r.current_d  = DW'(cd);
        r.current_q  = DW'(cq);
        r.volt_alpha = DW'(val);
        r.volt_beta  = DW'(vbe);
        r.volt_a     = DW'(va);
        r.volt_b     = DW'(vb);
        r.volt_c     = DW'(vc);
        return r;
    endfunction

    function automatic logic [DW-1:0] pick_sample();
        logic [DW-1:0] edges [6];
        edges = '{16'h8000, 16'h8001, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF};
        if ($urandom_range(0, 5) == 0) begin
            return edges[$urandom_range(0, 5)];
        end
        if ($urandom_range(0, 7) == 0) begin
            return DW'($urandom_range(0, 63)) - DW'(32);
        end
        return DW'($urandom);
    endfunction

    function automatic foc_in_t random_item();
        foc_in_t it;
        if ($urandom_range(0, 4) == 0) begin
            it.angle = {2'($urandom_range(0, 3)), 14'h0} + DW'($urandom_range(0, 2)) - DW'(1);
        end else begin
            it.angle = DW'($urandom);
        end
        it.current_a  = pick_sample();
        it.current_b  = pick_sample();
        it.current_c  = pick_sample();
        it.volt_d_cmd = pick_sample();
        it.volt_q_cmd = pick_sample();
        return it;
    endfunction

    task automatic check_field(input string name, input logic [DW-1:0] want,
                               input logic [DW-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, $signed(want), $signed(got));
            errors++;
        end
    endtask

    task automatic offer(input foc_in_t it, input bit typed, input foc_out_t res);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= it;
        offer_typed     <= typed;
        offer_res       <= res;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    task automatic idle_sender(input int cycles);
        i_s_axis_tvalid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                expected_results.push_back(offer_typed ? offer_res : transform(i_s_axis_tdata));
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    $error("Result item arrived with no expected result waiting.");
                    errors++;
                end else begin
                    oldest_res = expected_results.pop_front();
                    seen_res   = o_m_axis_tdata;
                    check_field("current_d", oldest_res.current_d, seen_res.current_d);
                    check_field("current_q", oldest_res.current_q, seen_res.current_q);
                    check_field("volt_alpha", oldest_res.volt_alpha, seen_res.volt_alpha);
                    check_field("volt_beta", oldest_res.volt_beta, seen_res.volt_beta);
                    check_field("volt_a", oldest_res.volt_a, seen_res.volt_a);
                    check_field("volt_b", oldest_res.volt_b, seen_res.volt_b);
                    check_field("volt_c", oldest_res.volt_c, seen_res.volt_c);
                end
            end
        end
    end

    initial begin
        i_m_axis_tready <= 1'b0;
        forever begin
            if (calm) begin
                i_m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end else if (hold_req) begin
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    end

    initial begin
        foc_out_t none;
        none = '0;
        errors = 0;
        hold_req = 1'b0;
        calm = 1'b0;
        i_rst_n <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata <= '0;
        offer_typed <= 1'b0;
        offer_res <= '0;

        directed_rows.push_back('{make_item(16'h0000, 0, 0, 0, 0, 0), 1'b1,
                                  make_res(0, 0, 0, 0, 0, 0, 0)});
        directed_rows.push_back('{make_item(16'hFFFF, 0, 0, 0, 0, 0), 1'b1,
                                  make_res(0, 0, 0, 0, 0, 0, 0)});
        directed_rows.push_back('{make_item(16'h4000, 0, 0, 0, 0, 0), 1'b1,
                                  make_res(0, 0, 0, 0, 0, 0, 0)});
        directed_rows.push_back('{make_item(16'h0000, -32768, -32768, -32768, 0, 0), 1'b1,
                                  make_res(-32767, 0, 0, 0, 0, 0, 0)});
        directed_rows.push_back('{make_item(16'h0000, 0, 0, 0, -32768, 0), 1'b1,
                                  make_res(0, 0, -32767, 0, -32767, 16384, 16384)});
        directed_rows.push_back('{make_item(16'h0000, 32767, 32767, -32768, 32767, -32768),
                                  1'b0, none});
        directed_rows.push_back('{make_item(16'h3FFF, 32767, -32768, 32767, -32768, 32767),
                                  1'b0, none});
        directed_rows.push_back('{make_item(16'h4000, -32768, 32767, -32768, 32767, 32767),
                                  1'b0, none});
        directed_rows.push_back('{make_item(16'h7FFF, 12345, -2222, 777, -32768, -32768),
                                  1'b0, none});
        directed_rows.push_back('{make_item(16'h8000, 32767, 0, 0, 32767, 0), 1'b0, none});
        directed_rows.push_back('{make_item(16'hBFFF, 0, 32767, 0, 0, 32767), 1'b0, none});
        directed_rows.push_back('{make_item(16'hC000, -1, -1, 1, -1, 1), 1'b0, none});
        directed_rows.push_back('{make_item(16'hFFFF, 32767, 32767, -32768, 32767, 32767),
                                  1'b0, none});
        directed_rows.push_back('{make_item(16'h2000, 32767, 32767, -32768, 32767, -32768),
                                  1'b0, none});
        directed_rows.push_back('{make_item(16'h6000, -32768, -32768, 32767, -32768, 32767),
                                  1'b0, none});
        directed_rows.push_back('{make_item(16'h0000, 0, 0, 0, -32768, 32767), 1'b0, none});
        directed_rows.push_back('{make_item(16'h0000, 0, 0, 0, -32768, -32768), 1'b0, none});
        directed_rows.push_back('{make_item(16'hA000, 1, -32768, 32767, 1, -1), 1'b0, none});
        directed_rows.push_back('{make_item(16'h0040, 100, 200, -300, 400, -500), 1'b0, none});
        directed_rows.push_back('{make_item(16'h003F, -100, -200, 300, -400, 500), 1'b0, none});
        directed_rows.push_back('{make_item(16'hE000, 32767, 32767, 32767, 32767, 32767),
                                  1'b0, none});

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            offer(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].res);
            if ($urandom_range(0, 3) == 0) begin
                idle_sender($urandom_range(1, 16));
            end
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 200) begin
                hold_req = 1'b1;
            end
            if (n == 400) begin
                i_s_axis_tvalid <= 1'b0;
                do @(posedge i_clk); while (expected_results.size() != 0);
            end
            if (n == RANDOM_ITEMS - CALM_ITEMS) begin
                calm = 1'b1;
            end
            offer(random_item(), 1'b0, none);
            if (!calm && !hold_req && $urandom_range(0, 3) == 0) begin
                idle_sender($urandom_range(1, 16));
            end
        end
        i_s_axis_tvalid <= 1'b0;

        do @(posedge i_clk); while (expected_results.size() != 0);
        repeat (20) @(posedge i_clk);

        if (errors == 0 && expected_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
